>>> rtl/core/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

	localparam int DEPTH_DEF     = 128;
	localparam int WORD_BITS_DEF = 32;

	localparam int KIND_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 8;
	localparam int RDVAL_W  = 32;
	localparam int LENGTH_W = 8;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_READ       = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TRUNCATE   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_DROP       = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
	} req_t;

	typedef struct packed {
		logic [RDVAL_W-1:0]  read_value;
		logic [LENGTH_W-1:0] new_length;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic execute;
		logic load;
	} cmd_t;

endpackage

>>> rtl/core/bdq_ctrl.sv
`timescale 1ns / 1ps

module bdq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bdq_pkg::cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign slot_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		cmd.load    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.execute = 1'b1;
				state_d     = S_RESP;
			end
			S_RESP: begin
				if (slot_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/bdq_datapath.sv
`timescale 1ns / 1ps

module bdq_datapath #(
	parameter int DEPTH     = bdq_pkg::DEPTH_DEF,
	parameter int WORD_BITS = bdq_pkg::WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bdq_pkg::cmd_t cmd,
	input  bdq_pkg::req_t req,
	output bdq_pkg::rsp_t rsp
);

	localparam int PW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > bdq_pkg::COUNT_W) ? CW : bdq_pkg::COUNT_W;

	logic [WORD_BITS-1:0] mem [DEPTH];

	bdq_pkg::req_t                 item_q;
	bdq_pkg::rsp_t                 out_q;
	logic [PW-1:0]                 front_q;
	logic [CW-1:0]                 count_q;
	logic [WORD_BITS-1:0]          rd_q;
	logic [bdq_pkg::STATUS_W-1:0]  st_q;
	logic                          rd_sel_q;

	logic [CMPW-1:0]               n_ext;
	logic [CMPW-1:0]               cnt_ext;
	logic                          full;
	logic                          empty;
	logic [PW:0]                   offset;
	logic [PW:0]                   sum;
	logic [PW:0]                   slot_w;
	logic [PW-1:0]                 slot;
	logic [PW-1:0]                 front_dec;
	logic [PW-1:0]                 front_d;
	logic [CW-1:0]                 count_d;
	logic [PW-1:0]                 addr;
	logic                          we;
	logic                          re;
	logic [bdq_pkg::STATUS_W-1:0]  st_d;
	logic [63:0]                   rd_wide;

	assign n_ext     = CMPW'(item_q.count);
	assign cnt_ext   = CMPW'(count_q);
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign front_dec = (front_q == '0) ? PW'(DEPTH - 1) : front_q - PW'(1);

	always_comb begin
		case (item_q.kind)
			bdq_pkg::KIND_PUSH_BACK: offset = (PW+1)'(count_q);
			bdq_pkg::KIND_POP_FRONT: offset = (PW+1)'(1);
			bdq_pkg::KIND_DROP:      offset = (n_ext > cnt_ext) ? (PW+1)'(count_q)
			                                                   : (PW+1)'(n_ext);
			default:                 offset = (PW+1)'(n_ext);
		endcase
	end

	assign sum    = {1'b0, front_q} + offset;
	assign slot_w = (sum >= (PW+1)'(DEPTH)) ? sum - (PW+1)'(DEPTH) : sum;
	assign slot   = slot_w[PW-1:0];

	always_comb begin
		front_d = front_q;
		count_d = count_q;
		addr    = slot;
		we      = 1'b0;
		re      = 1'b0;
		st_d    = bdq_pkg::ST_OK;
		case (item_q.kind)
			bdq_pkg::KIND_PUSH_FRONT: begin
				if (full) begin
					st_d = bdq_pkg::ST_FULL;
				end else begin
					front_d = front_dec;
					addr    = front_dec;
					we      = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			bdq_pkg::KIND_PUSH_BACK: begin
				if (full) begin
					st_d = bdq_pkg::ST_FULL;
				end else begin
					we      = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			bdq_pkg::KIND_POP_FRONT: begin
				if (empty) begin
					st_d = bdq_pkg::ST_EMPTY;
				end else begin
					addr    = front_q;
					re      = 1'b1;
					front_d = slot;
					count_d = count_q - CW'(1);
				end
			end
			bdq_pkg::KIND_READ: begin
				if (n_ext >= cnt_ext) begin
					st_d = bdq_pkg::ST_RANGE;
				end else begin
					re = 1'b1;
				end
			end
			bdq_pkg::KIND_TRUNCATE: begin
				if (n_ext > cnt_ext) begin
					st_d = bdq_pkg::ST_RANGE;
				end else begin
					count_d = CW'(n_ext);
				end
			end
			bdq_pkg::KIND_DROP: begin
				front_d = slot;
				if (n_ext > cnt_ext) begin
					count_d = '0;
					st_d    = bdq_pkg::ST_EMPTY;
				end else begin
					count_d = count_q - CW'(n_ext);
				end
			end
			default: begin
				st_d = bdq_pkg::ST_RANGE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.execute && we) begin
			mem[addr] <= WORD_BITS'(item_q.value);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute && re) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.execute) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req;
		end
		if (cmd.execute) begin
			st_q     <= st_d;
			rd_sel_q <= re;
		end
		if (cmd.load) begin
			out_q.read_value <= rd_sel_q ? rd_wide[bdq_pkg::RDVAL_W-1:0] : '0;
			out_q.new_length <= bdq_pkg::LENGTH_W'(count_q);
			out_q.status     <= st_q;
		end
	end

	assign rd_wide = 64'(rd_q);
	assign rsp     = out_q;

endmodule

>>> rtl/core/bounded_array_deque.sv
`timescale 1ns / 1ps
// channel | valid     | ready     | payload
// request | req_valid | req_ready | req (bdq_pkg::req_t: kind, value, count)
// result  | rsp_valid | rsp_ready | rsp (bdq_pkg::rsp_t: read_value, new_length, status)
//
// Each item passes through capture, execute against the element memory, then
// load into the result register; the registered memory read sets this order.
// req_ready is high only while no item is in flight; a waiting result does not
// hold off the next request, but a second result holds in the load step, with
// req_ready low, until the result register drains.
// Reset empties the list at once; the element memory is not cleared.

module bounded_array_deque #(
	parameter int DEPTH     = bdq_pkg::DEPTH_DEF,
	parameter int WORD_BITS = bdq_pkg::WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bdq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bdq_pkg::rsp_t rsp
);

	bdq_pkg::cmd_t cmd;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	bdq_datapath #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

>>> rtl/core/bdq_checker.sv
`timescale 1ns / 1ps

module bdq_checker #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input bdq_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input bdq_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an item is in flight");

	a_value_ok_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != bdq_pkg::ST_OK |-> rsp.read_value == '0)
		else $error("read value on a failed operation");

	a_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == bdq_pkg::ST_FULL |-> rsp.new_length == 8'(DEPTH))
		else $error("full status with list not full");

	a_empty_length: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == bdq_pkg::ST_EMPTY |-> rsp.new_length == '0)
		else $error("empty status with elements held");

endmodule

bind bounded_array_deque bdq_checker #(
	.DEPTH (DEPTH)
) u_bdq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
